FILE: hw/rtl/high_side_switch_fuse_controller_assert.svh
// Assertion macros used by the checker file.
`ifndef HIGH_SIDE_SWITCH_FUSE_CONTROLLER_ASSERT_SVH
`define HIGH_SIDE_SWITCH_FUSE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define HSSFC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hssfc: same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define HSSFC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hssfc: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define HSSFC_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("hssfc: reset check failed");

`endif

FILE: hw/rtl/hssfc_pkg.sv
`default_nettype none

package hssfc_pkg;

   typedef enum logic [1:0] {
      ST_OFF   = 2'd0,
      ST_ON    = 2'd1,
      ST_OC    = 2'd2,
      ST_FAULT = 2'd3
   } state_type;

   localparam logic [1:0] RM_NO_RETRY = 2'd0;
   localparam logic [1:0] RM_COUNTED  = 2'd1;

   localparam logic [15:0] SENSE_FAULT_LEVEL = 16'd30000;
   localparam logic [7:0]  COUNT_MAX         = 8'd255;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam logic [2:0] REG_INRUSH_TIME  = 3'd0;
   localparam logic [2:0] REG_CURRENT_LIM  = 3'd1;
   localparam logic [2:0] REG_INRUSH_LIM   = 3'd2;
   localparam logic [2:0] REG_RESET_MODE   = 3'd3;
   localparam logic [2:0] REG_RETRY_LIMIT  = 3'd4;
   localparam logic [2:0] REG_RETRY_TIME   = 3'd5;

   typedef struct packed {
      logic [31:0] inrush_time_ms;
      logic [15:0] current_limit;
      logic [15:0] inrush_current_limit;
      logic [1:0]  reset_mode;
      logic [7:0]  retry_limit;
      logic [31:0] retry_time_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        enabled;
      logic        request_on;
      logic        outputs_ok;
      logic [15:0] raw_sense;
      logic [15:0] load_current;
   } item_type;

   typedef struct packed {
      state_type   mode_state;
      logic [31:0] inrush_start_ms;
      logic [31:0] trip_time_ms;
      logic [7:0]  oc_counter;
      logic        drive_pin;
      logic        diag_pin;
      logic        inrush_flag;
   } chan_type;

endpackage

`default_nettype wire

FILE: hw/rtl/high_side_switch_fuse_controller.sv
// Channel  Direction  Payload (tdata, lowest bit first)
// req      in         now_ms[31:0] enabled[32] request_on[33] outputs_ok[34]
//                     raw_sense[50:35] load_current[66:51], zero fill to 72
// rsp      out        channel_state[1:0] previous_state[3:2] switch_drive[4]
//                     diag_enable[5] inrush_active[6] overcurrent_count[14:7]
// csr      in/out     APB, six registers at byte addresses 0x00..0x14
//
// The channel state advances at the edge that accepts a transfer, and its
// result lands in the output register at that same edge. One update per
// cycle is sustained while results drain; the state loop is one pass
// through two 32-bit add-and-compare paths. A stalled result holds its
// register, and req_tready stays high as long as the output register drains
// in that cycle. Reset clears the channel state, the registers and the
// output valid.
`default_nettype none

module high_side_switch_fuse_controller (
   input  wire                                   clock,
   input  wire                                   reset,
   // now_ms, enabled, request_on, outputs_ok, raw_sense, load_current
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [71:0]                           req_tdata,
   // channel_state, previous_state, switch_drive, diag_enable,
   // inrush_active, overcurrent_count
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [15:0]                           rsp_tdata,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [hssfc_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire  [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import hssfc_pkg::*;

   cfg_type   cfg;
   item_type  item;
   chan_type  chan_ff;
   chan_type  chan_in;
   chan_type  chan_next;
   logic      accept;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic [15:0] rsp_data_ff;
   logic [15:0] rsp_data_in;

   hssfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Unpack the update from the lowest bit up.
   assign item.now_ms       = req_tdata[31:0];
   assign item.enabled      = req_tdata[32];
   assign item.request_on   = req_tdata[33];
   assign item.outputs_ok   = req_tdata[34];
   assign item.raw_sense    = req_tdata[50:35];
   assign item.load_current = req_tdata[66:51];

   hssfc_step u_step (
      .cfg  (cfg),
      .item (item),
      .cur  (chan_ff),
      .nxt  (chan_next)
   );

   // Outside reset, take a new transfer whenever the output register is empty or draining.
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      chan_in      = chan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         chan_in      = chan_next;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, chan_next.oc_counter, chan_next.inrush_flag,
                         chan_next.diag_pin, chan_next.drive_pin,
                         chan_ff.mode_state, chan_next.mode_state};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff      <= '{mode_state: ST_OFF, default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/hssfc_csr.sv
`default_nettype none

module hssfc_csr (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_psel,
   input  wire                                    csr_penable,
   input  wire                                    csr_pwrite,
   input  wire  [hssfc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire  [31:0]                            csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready,
   output hssfc_pkg::cfg_type                     cfg
);
   import hssfc_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_INRUSH_TIME: cfg_in.inrush_time_ms       = csr_pwdata;
            REG_CURRENT_LIM: cfg_in.current_limit        = csr_pwdata[15:0];
            REG_INRUSH_LIM:  cfg_in.inrush_current_limit = csr_pwdata[15:0];
            REG_RESET_MODE:  cfg_in.reset_mode           = csr_pwdata[1:0];
            REG_RETRY_LIMIT: cfg_in.retry_limit          = csr_pwdata[7:0];
            REG_RETRY_TIME:  cfg_in.retry_time_ms        = csr_pwdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_INRUSH_TIME: csr_prdata = cfg_ff.inrush_time_ms;
         REG_CURRENT_LIM: csr_prdata = {16'd0, cfg_ff.current_limit};
         REG_INRUSH_LIM:  csr_prdata = {16'd0, cfg_ff.inrush_current_limit};
         REG_RESET_MODE:  csr_prdata = {30'd0, cfg_ff.reset_mode};
         REG_RETRY_LIMIT: csr_prdata = {24'd0, cfg_ff.retry_limit};
         REG_RETRY_TIME:  csr_prdata = cfg_ff.retry_time_ms;
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/hssfc_step.sv
`default_nettype none

// Next channel state for one update; later checks override earlier ones.
module hssfc_step (
   input  wire hssfc_pkg::cfg_type   cfg,
   input  wire hssfc_pkg::item_type  item,
   input  wire hssfc_pkg::chan_type  cur,
   output hssfc_pkg::chan_type       nxt
);
   import hssfc_pkg::*;

   logic [31:0] inrush_end;
   logic [31:0] retry_at;
   logic        inrush_open;
   logic        trip;
   logic [7:0]  count_inc;

   assign inrush_end  = cfg.inrush_time_ms + cur.inrush_start_ms;
   assign retry_at    = cfg.retry_time_ms + cur.trip_time_ms;
   assign inrush_open = inrush_end > item.now_ms;
   assign trip        = inrush_open ? (item.load_current > cfg.inrush_current_limit)
                                    : (item.load_current > cfg.current_limit);
   assign count_inc   = (cur.oc_counter == COUNT_MAX) ? cur.oc_counter
                                                      : cur.oc_counter + 8'd1;

   always_comb begin
      nxt = cur;
      if (!item.enabled) begin
         nxt.drive_pin  = 1'b0;
         nxt.diag_pin   = 1'b0;
         nxt.oc_counter = 8'd0;
         nxt.mode_state = ST_OFF;
      end else begin
         nxt.inrush_flag = inrush_open;
         if (item.raw_sense > SENSE_FAULT_LEVEL) begin
            nxt.mode_state = ST_FAULT;
         end
         case (nxt.mode_state)
            ST_OFF: begin
               nxt.drive_pin  = 1'b0;
               nxt.diag_pin   = 1'b0;
               nxt.oc_counter = 8'd0;
               if (item.request_on && item.outputs_ok) begin
                  nxt.inrush_start_ms = item.now_ms;
                  nxt.mode_state      = ST_ON;
               end
            end
            ST_ON: begin
               nxt.drive_pin = 1'b1;
               nxt.diag_pin  = 1'b1;
               if (!item.request_on) begin
                  nxt.mode_state = ST_OFF;
               end
               if (trip) begin
                  nxt.trip_time_ms = item.now_ms;
                  nxt.oc_counter   = count_inc;
                  nxt.mode_state   = ST_OC;
               end
               if (!item.outputs_ok) begin
                  nxt.mode_state = ST_OFF;
               end
            end
            ST_OC: begin
               nxt.drive_pin = 1'b0;
               if (cfg.reset_mode == RM_NO_RETRY) begin
                  nxt.mode_state = ST_FAULT;
               end
               if (cur.oc_counter >= cfg.retry_limit && cfg.reset_mode == RM_COUNTED) begin
                  nxt.mode_state = ST_FAULT;
               end
               if (retry_at < item.now_ms) begin
                  nxt.inrush_start_ms = item.now_ms;
                  nxt.mode_state      = ST_ON;
               end
               if (!item.request_on) begin
                  nxt.mode_state = ST_OFF;
               end
            end
            default: begin
               nxt.drive_pin = 1'b0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/hssfc_checker.sv
`default_nettype none
`include "high_side_switch_fuse_controller_assert.svh"

module hssfc_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [15:0] rsp_tdata
);
   import hssfc_pkg::*;

   logic       drive_high;
   logic       drive_source_ok;
   logic [1:0] cur_state;
   logic [1:0] prev_state;

   assign cur_state       = rsp_tdata[1:0];
   assign prev_state      = rsp_tdata[3:2];
   assign drive_high      = rsp_tdata[4];
   assign drive_source_ok = prev_state == ST_ON && cur_state != ST_FAULT;

   // A driven switch only comes from a channel that was on and has not faulted.
   `HSSFC_ASSERT_IMPLY(a_drive_from_on, clock, reset, rsp_tvalid && drive_high, drive_source_ok)

   // Every accepted update shows a result in the next cycle.
   `HSSFC_ASSERT_NEXT(a_accept_gives_result, clock, reset, req_tvalid && req_tready, rsp_tvalid)

   // Hold a stalled result unchanged.
   `HSSFC_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // Drop any pending result on reset.
   `HSSFC_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_tvalid)

endmodule

bind high_side_switch_fuse_controller hssfc_checker u_hssfc_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_high_side_switch_fuse_controller.sv
module tb_high_side_switch_fuse_controller;
   timeunit 1ns;
   timeprecision 1ps;

   import hssfc_pkg::*;

   // Retry modes that the package leaves unnamed.
   localparam logic [1:0] RM_ENDLESS = 2'd2;
   localparam logic [1:0] RM_UNUSED  = 2'd3;

   localparam int RUN_LIMIT      = 200000;  // cycles, many times the slowest clean run
   localparam int SATURATE_STEPS = 530;     // enough back-to-back trips to pin the count at max

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_tvalid  = 1'b0;
   logic                       req_tready;
   // now_ms, enabled, request_on, outputs_ok, raw_sense, load_current, zero fill
   logic [71:0]                req_tdata   = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready  = 1'b0;
   // channel_state, previous_state, switch_drive, diag_enable, inrush_active,
   // overcurrent_count, zero fill
   logic [15:0]                rsp_tdata;
   logic                       csr_psel    = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]  csr_paddr   = '0;
   logic [31:0]                csr_pwdata  = '0;
   logic [31:0]                csr_prdata;
   logic                       csr_pready;

   // One result transfer, highest field first so that it overlays rsp_tdata[14:0].
   typedef struct packed {
      logic [7:0] trips;
      logic       inrush;
      logic       diag;
      logic       drive;
      logic [1:0] prior_state;
      logic [1:0] next_state;
   } outcome_type;

   high_side_switch_fuse_controller DUT (.*);

   // Clock: 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow of the channel: register copy and fuse state, advanced once
   // per accepted update transfer.
   // ------------------------------------------------------------------
   cfg_type     shadow_cfg   = '0;
   state_type   fuse_state   = ST_OFF;
   logic [31:0] inrush_start = '0;
   logic [31:0] trip_stamp   = '0;
   logic [7:0]  trip_count   = '0;
   logic        drive_lvl    = 1'b0;
   logic        diag_lvl     = 1'b0;
   logic        inrush_open  = 1'b0;

   outcome_type awaited_outcomes[$];   // predicted results, oldest first
   item_type    pending_updates[$];    // stimulus not yet offered to the block

   int          mismatches     = 0;
   int          results_seen   = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          cycle_count    = 0;
   logic [31:0] ms_now         = '0;

   function automatic void log_trip(input logic [31:0] at_ms);
      trip_stamp = at_ms;
      if (trip_count != COUNT_MAX)
         trip_count = trip_count + 8'd1;
      fuse_state = ST_OC;
   endfunction

   // Advance the fuse by one update and return what the block must report.
   // Checks inside one state run in order, so a later one wins.
   function automatic outcome_type step_fuse(input item_type u);
      outcome_type o;
      logic [31:0] window_end;
      logic [31:0] retry_at;
      o.prior_state = fuse_state;
      if (!u.enabled) begin
         // Disable: pins low, count cleared, inrush flag left alone.
         drive_lvl  = 1'b0;
         diag_lvl   = 1'b0;
         trip_count = '0;
         fuse_state = ST_OFF;
      end else begin
         // Window test uses the start time held before this update; sum wraps.
         window_end  = shadow_cfg.inrush_time_ms + inrush_start;
         inrush_open = window_end > u.now_ms;
         if (u.raw_sense > SENSE_FAULT_LEVEL)
            fuse_state = ST_FAULT;
         case (fuse_state)
            ST_OFF: begin
               drive_lvl  = 1'b0;
               diag_lvl   = 1'b0;
               trip_count = '0;
               if (u.request_on && u.outputs_ok) begin
                  inrush_start = u.now_ms;
                  fuse_state   = ST_ON;
               end
            end
            ST_ON: begin
               drive_lvl = 1'b1;
               diag_lvl  = 1'b1;
               if (!u.request_on)
                  fuse_state = ST_OFF;
               if (u.load_current > shadow_cfg.current_limit && !inrush_open)
                  log_trip(u.now_ms);
               if (u.load_current > shadow_cfg.inrush_current_limit && inrush_open)
                  log_trip(u.now_ms);
               if (!u.outputs_ok)
                  fuse_state = ST_OFF;
            end
            ST_OC: begin
               drive_lvl = 1'b0;
               if (shadow_cfg.reset_mode == RM_NO_RETRY)
                  fuse_state = ST_FAULT;
               if (trip_count >= shadow_cfg.retry_limit &&
                   shadow_cfg.reset_mode == RM_COUNTED)
                  fuse_state = ST_FAULT;
               // Retry overrides a fault latched just above.
               retry_at = shadow_cfg.retry_time_ms + trip_stamp;
               if (retry_at < u.now_ms) begin
                  inrush_start = u.now_ms;
                  fuse_state   = ST_ON;
               end
               if (!u.request_on)
                  fuse_state = ST_OFF;
            end
            default: begin
               drive_lvl = 1'b0;
            end
         endcase
      end
      o.next_state = fuse_state;
      o.drive      = drive_lvl;
      o.diag       = diag_lvl;
      o.inrush     = inrush_open;
      o.trips      = trip_count;
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("tb: result %0d: %s", results_seen, msg);
   endtask

   // ------------------------------------------------------------------
   // Update driver: predict on every accepted transfer, then offer the
   // next pending update unless the sender idles this cycle.
   // ------------------------------------------------------------------
   int send_quiet = 0;

   always @(posedge clock) begin : drive_updates
      item_type arrived;
      item_type nxt;
      logic     idle_now;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            arrived.now_ms       = req_tdata[31:0];
            arrived.enabled      = req_tdata[32];
            arrived.request_on   = req_tdata[33];
            arrived.outputs_ok   = req_tdata[34];
            arrived.raw_sense    = req_tdata[50:35];
            arrived.load_current = req_tdata[66:51];
            awaited_outcomes.push_back(step_fuse(arrived));
         end
         // Quiet stretches give runs of back-to-back transfers.
         if (send_quiet > 0) begin
            send_quiet--;
            idle_now = 1'b0;
         end else begin
            if ($urandom_range(99) < 3)
               send_quiet = $urandom_range(8, 40);
            idle_now = $urandom_range(99) < send_idle_pct;
         end
         // Hold the offered transfer until it is taken.
         if (!req_tvalid || req_tready) begin
            if (pending_updates.size() != 0 && !idle_now) begin
               nxt = pending_updates.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {5'b0, nxt.load_current, nxt.raw_sense, nxt.outputs_ok,
                              nxt.request_on, nxt.enabled, nxt.now_ms};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor: compare each accepted transfer with the oldest
   // prediction, then decide whether to stall the next cycle.
   // ------------------------------------------------------------------
   int recv_quiet = 0;

   always @(posedge clock) begin : check_results
      outcome_type got;
      outcome_type want;
      logic        stall_now;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got = outcome_type'(rsp_tdata[14:0]);
            if (awaited_outcomes.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_tdata));
            end else begin
               want = awaited_outcomes.pop_front();
               if (got.next_state != want.next_state)
                  report_mismatch($sformatf("channel_state %0d, want %0d",
                                            got.next_state, want.next_state));
               if (got.prior_state != want.prior_state)
                  report_mismatch($sformatf("previous_state %0d, want %0d",
                                            got.prior_state, want.prior_state));
               if (got.drive != want.drive)
                  report_mismatch($sformatf("switch_drive %b, want %b",
                                            got.drive, want.drive));
               if (got.diag != want.diag)
                  report_mismatch($sformatf("diag_enable %b, want %b",
                                            got.diag, want.diag));
               if (got.inrush != want.inrush)
                  report_mismatch($sformatf("inrush_active %b, want %b",
                                            got.inrush, want.inrush));
               if (got.trips != want.trips)
                  report_mismatch($sformatf("overcurrent_count %0d, want %0d",
                                            got.trips, want.trips));
            end
         end
         if (recv_quiet > 0) begin
            recv_quiet--;
            stall_now = 1'b0;
         end else begin
            if ($urandom_range(99) < 3)
               recv_quiet = $urandom_range(8, 40);
            stall_now = $urandom_range(99) < recv_stall_pct;
         end
         rsp_tready <= !stall_now;
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == RUN_LIMIT) begin
         $display("tb_high_side_switch_fuse_controller: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Register access and stimulus helpers
   // ------------------------------------------------------------------

   // Write one register: setup cycle, then access until pready; mirror it.
   task automatic write_csr(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_INRUSH_TIME: shadow_cfg.inrush_time_ms       = value;
         REG_CURRENT_LIM: shadow_cfg.current_limit        = value[15:0];
         REG_INRUSH_LIM:  shadow_cfg.inrush_current_limit = value[15:0];
         REG_RESET_MODE:  shadow_cfg.reset_mode           = value[1:0];
         REG_RETRY_LIMIT: shadow_cfg.retry_limit          = value[7:0];
         REG_RETRY_TIME:  shadow_cfg.retry_time_ms        = value;
         default: ;
      endcase
   endtask

   task automatic apply_cfg(input cfg_type c);
      write_csr(REG_INRUSH_TIME, c.inrush_time_ms);
      write_csr(REG_CURRENT_LIM, {16'b0, c.current_limit});
      write_csr(REG_INRUSH_LIM,  {16'b0, c.inrush_current_limit});
      write_csr(REG_RESET_MODE,  {30'b0, c.reset_mode});
      write_csr(REG_RETRY_LIMIT, {24'b0, c.retry_limit});
      write_csr(REG_RETRY_TIME,  c.retry_time_ms);
   endtask

   // Wait until every update is taken and every result is back, then let
   // the pipeline settle.
   task automatic wait_drained();
      while (pending_updates.size() != 0 || req_tvalid || awaited_outcomes.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic queue_update(input logic [31:0] at_ms, input logic en, input logic req,
                               input logic ok, input logic [15:0] sense,
                               input logic [15:0] load);
      item_type u;
      u.now_ms       = at_ms;
      u.enabled      = en;
      u.request_on   = req;
      u.outputs_ok   = ok;
      u.raw_sense    = sense;
      u.load_current = load;
      pending_updates.push_back(u);
   endtask

   // Load value scattered around a threshold, clamped to the field.
   function automatic logic [15:0] around(input logic [15:0] center);
      int v;
      v = int'(center) + int'($urandom_range(0, 40)) - 20;
      if (v < 0)
         v = 0;
      if (v > 65535)
         v = 65535;
      return v[15:0];
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.inrush_time_ms = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 40);
      c.retry_time_ms  = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 30);
      c.current_limit        = 16'(($urandom_range(9) == 0) ? $urandom
                                                             : $urandom_range(0, 1500));
      c.inrush_current_limit = 16'(($urandom_range(9) == 0) ? $urandom
                                                             : $urandom_range(0, 3000));
      c.reset_mode  = 2'($urandom_range(0, 3));
      c.retry_limit = 8'(($urandom_range(9) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 5));
      return c;
   endfunction

   // Mostly a steadily running clock with the channel enabled and asked on;
   // loads cluster near the active limits so trips and retries happen often.
   task automatic queue_random_update();
      logic [15:0] sense;
      logic [15:0] load;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 85)
         ms_now = ms_now + $urandom_range(0, 6);
      else if (pick < 95)
         ms_now = ms_now + $urandom_range(7, 60);
      else
         ms_now = $urandom;
      pick = $urandom_range(99);
      if (pick < 4)
         sense = 16'($urandom_range(30001, 65535));
      else if (pick == 4)
         sense = SENSE_FAULT_LEVEL;
      else
         sense = 16'($urandom_range(0, 29999));
      case ($urandom_range(0, 9))
         0:          load = 16'($urandom);
         1, 2, 3, 4: load = around(shadow_cfg.current_limit);
         5, 6, 7:    load = around(shadow_cfg.inrush_current_limit);
         default:    load = 16'($urandom_range(0, 60));
      endcase
      queue_update(ms_now, $urandom_range(99) >= 3, $urandom_range(99) >= 8,
                   $urandom_range(99) >= 5, sense, load);
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin : run_sequence
      cfg_type c;
      int      k;
      int      n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Sender idles lightly, receiver stalls heavily.
      send_idle_pct  = 17;
      recv_stall_pct = 65;

      // Directed walk: 5 ms inrush window, counted retry up to two trips.
      c.inrush_time_ms       = 32'd5;
      c.current_limit        = 16'd100;
      c.inrush_current_limit = 16'd300;
      c.reset_mode           = RM_COUNTED;
      c.retry_limit          = 8'd2;
      c.retry_time_ms        = 32'd3;
      apply_cfg(c);

      queue_update(32'd10, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0);        // disabled
      queue_update(32'd11, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0);        // on blocked by outputs_ok
      queue_update(32'd12, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0);        // switch on, pin still low
      queue_update(32'd13, 1'b1, 1'b1, 1'b1, 16'd0, 16'd200);      // above steady, inside window
      queue_update(32'd14, 1'b1, 1'b1, 1'b1, 16'd0, 16'd400);      // above inrush limit: trip
      queue_update(32'd15, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0);        // wait out retry time
      queue_update(32'd18, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0);        // retry
      queue_update(32'd19, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0);
      queue_update(32'd24, 1'b1, 1'b1, 1'b1, 16'd0, 16'd101);      // window closed: second trip
      queue_update(32'd25, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0);        // count reached: fault
      queue_update(32'd26, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0);        // fault holds
      queue_update(32'd27, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0);        // disable clears fault
      queue_update(32'd28, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0);
      queue_update(32'd29, 1'b1, 1'b0, 1'b1, 16'd0, 16'd0);        // request drop
      queue_update(32'd30, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0);
      queue_update(32'd31, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0);        // permission drop
      queue_update(32'd32, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0);
      queue_update(32'd33, 1'b1, 1'b1, 1'b1, 16'd30000, 16'd0);    // sense at threshold
      queue_update(32'd34, 1'b1, 1'b1, 1'b1, 16'd30001, 16'd0);    // sense fault
      queue_update(32'd35, 1'b0, 1'b1, 1'b1, 16'hFFFF, 16'd0);     // disable keeps inrush flag
      queue_update(32'd36, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0);
      queue_update(32'd50, 1'b1, 1'b0, 1'b1, 16'd0, 16'hFFFF);     // trip beats request drop
      queue_update(32'd51, 1'b1, 1'b0, 1'b1, 16'd0, 16'd0);        // request drop leaves overcurrent
      queue_update(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0);
      queue_update(32'd0, 1'b1, 1'b1, 1'b1, 16'd0, 16'hFFFF);
      wait_drained();

      // Random phases, each with its own register setting.
      for (k = 0; k < 10; k++) begin
         if (k == 3) begin
            // Swap: sender idles heavily, receiver stalls lightly.
            send_idle_pct  = 65;
            recv_stall_pct = 17;
         end else if (k == 6) begin
            // No idling at all.
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         if (k == 0) begin
            c = '0;
         end else if (k == 3) begin
            c.inrush_time_ms       = 32'hFFFF_FFFF;
            c.current_limit        = 16'hFFFF;
            c.inrush_current_limit = 16'hFFFF;
            c.reset_mode           = RM_UNUSED;
            c.retry_limit          = 8'hFF;
            c.retry_time_ms        = 32'hFFFF_FFFF;
         end else if (k == 9) begin
            // Endless retry with zero limits: trip on every other update.
            c = '0;
            c.reset_mode = RM_ENDLESS;
         end else begin
            c = random_cfg();
         end
         apply_cfg(c);
         ms_now = (k == 5) ? 32'hFFFF_FFC0 : $urandom;
         if (k == 9) begin
            queue_update(ms_now, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0);
            for (n = 0; n < SATURATE_STEPS; n++) begin
               ms_now = ms_now + $urandom_range(1, 3);
               queue_update(ms_now, 1'b1, 1'b1, 1'b1, 16'($urandom_range(0, 30000)),
                            16'($urandom_range(1, 65535)));
            end
         end else begin
            for (n = 0; n < 45; n++)
               queue_random_update();
         end
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (mismatches == 0 && awaited_outcomes.size() == 0) begin
         $display("tb_high_side_switch_fuse_controller: done, clean");
      end else begin
         $display("tb_high_side_switch_fuse_controller: done, errors");
      end
      $finish;
   end

endmodule
